>>> design/assert_macros.svh
// Assertion helpers shared by the RTL of the kernel convolution block.
// Every macro expects signals named clk and rst in the calling scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define RKC_ASSERT_IMPLY(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// next-cycle implication
`define RKC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define RKC_ASSERT_IMPLY(lbl, ante, cons, msg)
`define RKC_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

>>> design/rkc_pkg.sv
// Shared types and constants of the RGB kernel convolution block.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package rkc_pkg;

  localparam int DIM_W      = 11;
  localparam int PIX_W      = 8;
  localparam int RGB_W      = 3 * PIX_W;
  localparam int COEF_W     = 16;
  localparam int CIDX_W     = 5;
  localparam int MODE_W     = 2;
  localparam int RAD_W      = 2;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 11;

  localparam logic [MODE_W-1:0] MODE_COEF  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_PIXEL = 2'd1;
  localparam logic [MODE_W-1:0] MODE_FLUSH = 2'd2;
  localparam logic [MODE_W-1:0] MODE_NONE  = 2'd3;

  localparam logic [CFG_IDX_W-1:0] REG_RADIUS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 2'd2;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_RUN,
    S_DRAIN,
    S_EMIT
  } state_t;

  typedef struct packed {
    logic [MODE_W-1:0]        mode;
    logic [PIX_W-1:0]         pixel_red;
    logic [PIX_W-1:0]         pixel_green;
    logic [PIX_W-1:0]         pixel_blue;
    logic [CIDX_W-1:0]        coef_index;
    logic signed [COEF_W-1:0] coef_value;
  } in_item_t;

  typedef struct packed {
    logic [PIX_W-1:0] out_red;
    logic [PIX_W-1:0] out_green;
    logic [PIX_W-1:0] out_blue;
    logic             frame_end;
  } out_item_t;

  // controller -> datapath
  typedef struct packed {
    logic take;
    logic tap_start;
    logic tap_step;
    logic emit;
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic can_emit;
    logic tap_last;
    logic pipe_busy;
    logic out_free;
  } sts_t;

endpackage

`default_nettype wire

>>> design/rkc_if.sv
// Channel interfaces of the kernel convolution block: input items, results
// and register writes. Depends on rkc_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface rkc_in_if;
  logic               valid;
  logic               ready;
  rkc_pkg::in_item_t  data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface rkc_out_if;
  logic               valid;
  logic               ready;
  rkc_pkg::out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface rkc_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [rkc_pkg::CFG_IDX_W-1:0]    index;
  logic [rkc_pkg::CFG_DATA_W-1:0]   data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

>>> design/rkc_ctrl.sv
// Sequencer of the kernel convolution block: takes items, runs the tap loop
// and hands results out. Depends on rkc_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module rkc_ctrl (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      in_valid,
  input  wire logic [rkc_pkg::MODE_W-1:0] in_mode,
  output logic                           in_ready,
  input  wire rkc_pkg::sts_t             sts,
  output rkc_pkg::cmd_t                  cmd
);
  import rkc_pkg::*;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_valid && (in_mode == MODE_PIXEL || in_mode == MODE_FLUSH)) begin
          state_next = S_CHECK;
        end
      end
      S_CHECK: begin
        state_next = sts.can_emit ? S_RUN : S_IDLE;
      end
      S_RUN: begin
        if (sts.tap_last) begin
          state_next = S_DRAIN;
        end
      end
      S_DRAIN: begin
        if (!sts.pipe_busy) begin
          state_next = S_EMIT;
        end
      end
      S_EMIT: begin
        if (sts.out_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    in_ready      = (state == S_IDLE);
    cmd.take      = (state == S_IDLE) && in_valid;
    cmd.tap_start = (state == S_CHECK) && sts.can_emit;
    cmd.tap_step  = (state == S_RUN);
    cmd.emit      = (state == S_EMIT) && sts.out_free;
  end

  `RKC_ASSERT_IMPLY(a_emit_slot_free, cmd.emit, sts.out_free, "result written over a pending one")
  `RKC_ASSERT_IMPLY(a_emit_drained, cmd.emit, !sts.pipe_busy, "result taken before sums settled")
  `RKC_ASSERT_NEXT(a_check_no_result, (state == S_CHECK) && !sts.can_emit, state == S_IDLE, "no-result check did not return to idle")

endmodule

`default_nettype wire

>>> design/rkc_datapath.sv
// Datapath of the kernel convolution block: registers, position counters,
// line store, coefficient table and the multiply-accumulate lane. Depends on rkc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module rkc_datapath #(
  parameter int MAX_WIDTH      = 1024,
  parameter int MAX_RADIUS     = 2,
  parameter int COEF_FRAC_BITS = 12
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire rkc_pkg::cmd_t                 cmd,
  output rkc_pkg::sts_t                      sts,
  input  wire logic                          cfg_we,
  input  wire logic [rkc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [rkc_pkg::CFG_DATA_W-1:0] cfg_data,
  input  wire rkc_pkg::in_item_t             in_data,
  input  wire logic                          out_ready,
  output logic                               out_valid,
  output rkc_pkg::out_item_t                 out_data
);
  import rkc_pkg::*;

  localparam int KSIZE      = 2 * MAX_RADIUS + 1;
  localparam int COEF_DEPTH = KSIZE * KSIZE;
  localparam int CK_W       = $clog2(COEF_DEPTH);
  localparam int LS_DEPTH   = KSIZE * MAX_WIDTH;
  localparam int LS_AW      = $clog2(LS_DEPTH);
  localparam int OFF_W      = LS_AW + 2;
  localparam int TW         = $clog2(MAX_RADIUS + 1) + 1;
  localparam int SW         = DIM_W + 2;
  localparam int PROD_W     = PIX_W + 1 + COEF_W;
  localparam int ACC_W      = PROD_W + CK_W;

  // registers
  logic [RAD_W-1:0] rad_reg;
  logic [DIM_W-1:0] width_reg, height_reg;

  // positions
  logic [DIM_W-1:0] in_col, in_row, out_col, out_row;
  logic [LS_AW-1:0] wr_addr, out_addr;

  logic signed [COEF_W-1:0] coef_tab [COEF_DEPTH];
  logic [RGB_W-1:0]         line_mem [LS_DEPTH];

  // tap loop
  logic signed [TW-1:0] di, dj;
  logic [CK_W-1:0]      k;

  logic [RGB_W-1:0]         rd_pix;
  logic signed [COEF_W-1:0] coef_q;
  logic                     v1, v2;
  logic signed [PROD_W-1:0] prod_r, prod_g, prod_b;
  logic signed [ACC_W-1:0]  acc_r, acc_g, acc_b;

  logic [RAD_W-1:0]     r_u;
  logic signed [TW-1:0] r_s;
  logic [DIM_W-1:0]     w_eff, h_eff, wm1, hm1;
  logic [DIM_W:0]       ny_raw, nx_raw;
  logic [DIM_W-1:0]     ny, nx;
  logic                 in_room, last_pos;
  logic signed [SW-1:0] ys, xs, yc, xc, dy, dx;
  logic signed [OFF_W-1:0] off, raw;
  logic [LS_AW-1:0]     tap_addr;
  logic                 pix_write;

  function automatic logic [PIX_W-1:0] finish(input logic signed [ACC_W-1:0] s);
    logic signed [ACC_W-1:0] q;
    q = s >>> COEF_FRAC_BITS;
    if (s < 0) return '0;
    else if (q > ACC_W'(255)) return '1;
    else return q[PIX_W-1:0];
  endfunction

  // effective settings
  always_comb begin
    r_u = rad_reg;
    if (r_u == '0) r_u = RAD_W'(1);
    if (int'(r_u) > MAX_RADIUS) r_u = RAD_W'(MAX_RADIUS);
    r_s = $signed(TW'(r_u));
    w_eff = width_reg;
    if (w_eff == '0) w_eff = DIM_W'(1);
    if (int'(w_eff) > MAX_WIDTH) w_eff = DIM_W'(MAX_WIDTH);
    h_eff = (height_reg == '0) ? DIM_W'(1) : height_reg;
    wm1 = w_eff - DIM_W'(1);
    hm1 = h_eff - DIM_W'(1);
  end

  // result readiness: the lowest-right window pixel must be in
  always_comb begin
    ny_raw  = {1'b0, out_row} + (DIM_W+1)'(r_u);
    nx_raw  = {1'b0, out_col} + (DIM_W+1)'(r_u);
    ny      = (ny_raw > {1'b0, hm1}) ? hm1 : ny_raw[DIM_W-1:0];
    nx      = (nx_raw > {1'b0, wm1}) ? wm1 : nx_raw[DIM_W-1:0];
    in_room = (in_row < h_eff) && (in_col < w_eff);
    last_pos = (out_row == hm1) && (out_col == wm1);
    sts.can_emit = (out_row < h_eff) && (out_col < w_eff) &&
                   ((in_row > ny) || ((in_row == ny) && (in_col > nx)));
    sts.tap_last  = (di == r_s) && (dj == r_s);
    sts.pipe_busy = v1 || v2;
    sts.out_free  = !out_valid || out_ready;
  end

  // tap address, relative to the output pixel's store slot
  always_comb begin
    ys = $signed({2'b0, out_row}) + SW'(di);
    xs = $signed({2'b0, out_col}) + SW'(dj);
    if (ys < 0) yc = '0;
    else if (ys > $signed({2'b0, hm1})) yc = $signed({2'b0, hm1});
    else yc = ys;
    if (xs < 0) xc = '0;
    else if (xs > $signed({2'b0, wm1})) xc = $signed({2'b0, wm1});
    else xc = xs;
    dy  = yc - $signed({2'b0, out_row});
    dx  = xc - $signed({2'b0, out_col});
    off = OFF_W'(dy * $signed({2'b0, w_eff})) + OFF_W'(dx);
    raw = $signed({2'b0, out_addr}) + off;
    if (raw < 0) raw = raw + $signed(OFF_W'(LS_DEPTH));
    else if (raw >= $signed(OFF_W'(LS_DEPTH))) raw = raw - $signed(OFF_W'(LS_DEPTH));
    tap_addr = raw[LS_AW-1:0];
  end

  assign pix_write = cmd.take && (in_data.mode == MODE_PIXEL) && in_room;

  // control registers and counters
  always_ff @(posedge clk) begin
    if (rst) begin
      rad_reg    <= RAD_W'(1);
      width_reg  <= DIM_W'(1024);
      height_reg <= DIM_W'(1024);
      in_col     <= '0;
      in_row     <= '0;
      out_col    <= '0;
      out_row    <= '0;
      wr_addr    <= '0;
      out_addr   <= '0;
      di         <= '0;
      dj         <= '0;
      k          <= '0;
      v1         <= 1'b0;
      v2         <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      v1 <= cmd.tap_step;
      v2 <= v1;

      if (pix_write) begin
        wr_addr <= (wr_addr == LS_AW'(LS_DEPTH - 1)) ? '0 : wr_addr + LS_AW'(1);
        if (in_col == wm1) begin
          in_col <= '0;
          in_row <= in_row + DIM_W'(1);
        end else begin
          in_col <= in_col + DIM_W'(1);
        end
      end

      if (cmd.tap_start) begin
        di <= -r_s;
        dj <= -r_s;
        k  <= '0;
      end else if (cmd.tap_step) begin
        k <= k + CK_W'(1);
        if (dj == r_s) begin
          dj <= -r_s;
          di <= di + TW'(1);
        end else begin
          dj <= dj + TW'(1);
        end
      end

      if (cmd.emit) begin
        out_valid <= 1'b1;
        if (last_pos) begin
          in_col   <= '0;
          in_row   <= '0;
          out_col  <= '0;
          out_row  <= '0;
          wr_addr  <= '0;
          out_addr <= '0;
        end else begin
          out_addr <= (out_addr == LS_AW'(LS_DEPTH - 1)) ? '0 : out_addr + LS_AW'(1);
          if (out_col == wm1) begin
            out_col <= '0;
            out_row <= out_row + DIM_W'(1);
          end else begin
            out_col <= out_col + DIM_W'(1);
          end
        end
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end

      if (cfg_we && cfg_index <= REG_HEIGHT) begin
        case (cfg_index)
          REG_RADIUS: rad_reg    <= cfg_data[RAD_W-1:0];
          REG_WIDTH:  width_reg  <= cfg_data;
          REG_HEIGHT: height_reg <= cfg_data;
          default:    rad_reg    <= rad_reg;
        endcase
        in_col   <= '0;
        in_row   <= '0;
        out_col  <= '0;
        out_row  <= '0;
        wr_addr  <= '0;
        out_addr <= '0;
      end
    end
  end

  // coefficient table, cleared by reset
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < COEF_DEPTH; i++) begin
        coef_tab[i] <= '0;
      end
    end else if (cmd.take && in_data.mode == MODE_COEF &&
                 int'(in_data.coef_index) < COEF_DEPTH) begin
      coef_tab[CK_W'(in_data.coef_index)] <= in_data.coef_value;
    end
  end

  // line store: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (pix_write) begin
      line_mem[wr_addr] <= {in_data.pixel_red, in_data.pixel_green, in_data.pixel_blue};
    end
    if (cmd.tap_step) begin
      rd_pix <= line_mem[tap_addr];
      coef_q <= coef_tab[k];
    end
  end

  // multiply then accumulate
  always_ff @(posedge clk) begin
    if (v1) begin
      prod_r <= $signed({1'b0, rd_pix[3*PIX_W-1:2*PIX_W]}) * coef_q;
      prod_g <= $signed({1'b0, rd_pix[2*PIX_W-1:PIX_W]}) * coef_q;
      prod_b <= $signed({1'b0, rd_pix[PIX_W-1:0]}) * coef_q;
    end
    if (cmd.tap_start) begin
      acc_r <= '0;
      acc_g <= '0;
      acc_b <= '0;
    end else if (v2) begin
      acc_r <= acc_r + ACC_W'(prod_r);
      acc_g <= acc_g + ACC_W'(prod_g);
      acc_b <= acc_b + ACC_W'(prod_b);
    end
    if (cmd.emit) begin
      out_data.out_red   <= finish(acc_r);
      out_data.out_green <= finish(acc_g);
      out_data.out_blue  <= finish(acc_b);
      out_data.frame_end <= last_pos;
    end
  end

endmodule

`default_nettype wire

>>> design/rgb_kernel_convolution.sv
// Top level of the RGB kernel convolution block: sequencer plus datapath.
// Depends on rkc_pkg, rkc_if, rkc_ctrl and rkc_datapath.
`timescale 1ns / 1ps
`default_nettype none

// Streaming 2-D convolution of RGB pixels with a square (2r+1)x(2r+1) table
// of signed Q4.12 coefficients, borders replicated by clamping coordinates.
// Items on src carry a mode: load coefficient, pixel (raster order), or
// flush. Results on dst come in raster order, lagging the input by r rows
// plus r pixels; after the last pixel, flush items drain the rest, and
// frame_end marks the final pixel of the frame. Each channel sum is clamped
// to zero when negative, shifted down by the fraction bits and saturated at
// 255. Register writes (radius, width, height) restart the frame but keep
// the coefficients; write them only while the block is idle.
// A coefficient load or a pixel that completes no window leaves the block
// idle again. For an item that yields a result, all (2r+1)^2 window taps are
// read, one per cycle, from the single-read-port line store and fed through
// one shared multiply-accumulate lane. A finished result waits in the output
// register, so the next item can be taken while dst is stalled.
module rgb_kernel_convolution #(
  parameter int MAX_WIDTH      = 1024,
  parameter int MAX_RADIUS     = 2,
  parameter int COEF_FRAC_BITS = 12
) (
  input wire logic  clk,
  input wire logic  rst,
  rkc_cfg_if.sink   cfg,
  rkc_in_if.sink    src,
  rkc_out_if.source dst
);
  import rkc_pkg::*;

  cmd_t cmd;
  sts_t sts;

  // register writes are always taken
  assign cfg.ready = 1'b1;

  // sequencer: one item at a time
  rkc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (src.valid),
    .in_mode  (src.data.mode),
    .in_ready (src.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // storage, counters and arithmetic
  rkc_datapath #(
    .MAX_WIDTH      (MAX_WIDTH),
    .MAX_RADIUS     (MAX_RADIUS),
    .COEF_FRAC_BITS (COEF_FRAC_BITS)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .sts       (sts),
    .cfg_we    (cfg.valid),
    .cfg_index (cfg.index),
    .cfg_data  (cfg.data),
    .in_data   (src.data),
    .out_ready (dst.ready),
    .out_valid (dst.valid),
    .out_data  (dst.data)
  );

endmodule

`default_nettype wire
